// File: hdl/pfde_pkg.sv
// ----------------------------------------------------------------------------
// pfde_pkg
// shared codes, command and status types of the page framebuffer draw engine
// ----------------------------------------------------------------------------
package pfde_pkg;

    // action codes on the input beat
    localparam logic [2:0] ACT_PIXEL = 3'd0;
    localparam logic [2:0] ACT_LINE  = 3'd1;
    localparam logic [2:0] ACT_CLEAR = 3'd2;
    localparam logic [2:0] ACT_FILL  = 3'd3;
    localparam logic [2:0] ACT_READ  = 3'd4;

    // color codes
    localparam logic [1:0] COLOR_SET = 2'd0;
    localparam logic [1:0] COLOR_CLR = 2'd1;
    localparam logic [1:0] COLOR_XOR = 2'd2;

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONES = 8'hFF;

    // classified command kinds
    typedef enum logic [2:0] {
        OP_NOP,
        OP_PIXEL,
        OP_LINE,
        OP_CLEAR,
        OP_FILL,
        OP_READ
    } t_op;

    // control part of a queued command
    typedef struct packed {
        t_op        op;
        logic       ign;
        logic [1:0] color;
        logic [7:0] mask;
    } t_cmd_ctl;

    // back end status toward the front
    typedef struct packed {
        logic init_busy;
    } t_back_stat;

    // back end sequencer states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DRAW,
        ST_SWEEP,
        ST_READ
    } t_state;

endpackage

// File: hdl/pfde_ram.sv
// ----------------------------------------------------------------------------
// pfde_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module pfde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/pfde_fifo.sv
// ----------------------------------------------------------------------------
// pfde_fifo
// small register queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
module pfde_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_data[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wptr] <= i_wdata;
        end
    end

endmodule

// File: hdl/pfde_front.sv
// ----------------------------------------------------------------------------
// pfde_front
// classifies an input beat: screen tests, clipping, byte span and bit mask
// ----------------------------------------------------------------------------
module pfde_front #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64,
    parameter int STORE_BYTES   = 1024,
    parameter int ADDR_W        = 10
) (
    input  logic [2:0]         i_action,
    input  logic signed [15:0] i_x_start,
    input  logic signed [15:0] i_x_end,
    input  logic signed [15:0] i_y_pos,
    input  logic [1:0]         i_color,
    input  logic [9:0]         i_byte_index,
    output pfde_pkg::t_cmd_ctl o_ctl,
    output logic [ADDR_W-1:0]  o_first,
    output logic [ADDR_W-1:0]  o_last
);

    import pfde_pkg::*;

    localparam logic [15:0] W16    = 16'(SCREEN_WIDTH);
    localparam logic [15:0] WMAX16 = 16'(SCREEN_WIDTH - 1);
    localparam logic [15:0] H16    = 16'(SCREEN_HEIGHT);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

    logic                    y_ok;
    logic                    x_ok;
    logic signed [15:0]      xs_clip;
    logic signed [15:0]      xe_clip;
    logic                    span_empty;
    logic [ADDR_W-1:0]       page_base;
    logic                    rd_ok;
    logic                    color_used;

    assign y_ok = !i_y_pos[15] && (16'(i_y_pos) < H16);
    assign x_ok = !i_x_start[15] && (16'(i_x_start) < W16);

    // clip the run to the screen columns
    assign xs_clip = i_x_start[15] ? 16'sd0 : i_x_start;
    assign xe_clip = (!i_x_end[15] && (16'(i_x_end) > WMAX16)) ? $signed(WMAX16) : i_x_end;
    assign span_empty = (xs_clip > xe_clip);

    assign page_base  = ADDR_W'(32'(i_y_pos[15:3]) * 32'(SCREEN_WIDTH));
    assign rd_ok      = (32'(i_byte_index) < 32'(STORE_BYTES));
    assign color_used = (i_color != 2'd3);

    always_comb begin
        o_ctl.op    = OP_NOP;
        o_ctl.ign   = 1'b0;
        o_ctl.color = i_color;
        o_ctl.mask  = 8'(8'd1 << i_y_pos[2:0]);
        o_first     = '0;
        o_last      = '0;
        case (i_action)
            ACT_PIXEL: begin
                o_first = page_base + ADDR_W'(xs_clip);
                o_last  = o_first;
                if (!(x_ok && y_ok)) begin
                    o_ctl.ign = 1'b1;
                end else if (color_used) begin
                    o_ctl.op = OP_PIXEL;
                end
            end
            ACT_LINE: begin
                o_first = page_base + ADDR_W'(xs_clip);
                o_last  = page_base + ADDR_W'(xe_clip);
                if (!y_ok || span_empty) begin
                    o_ctl.ign = 1'b1;
                end else if (color_used) begin
                    o_ctl.op = OP_LINE;
                end
            end
            ACT_CLEAR: begin
                o_ctl.op = OP_CLEAR;
                o_last   = LAST_ADDR;
            end
            ACT_FILL: begin
                o_ctl.op = OP_FILL;
                o_last   = LAST_ADDR;
            end
            ACT_READ: begin
                o_first = ADDR_W'(i_byte_index);
                o_last  = o_first;
                if (rd_ok) begin
                    o_ctl.op = OP_READ;
                end
            end
            default: begin
                o_ctl.op = OP_NOP;
            end
        endcase
    end

endmodule

// File: hdl/pfde_back.sv
// ----------------------------------------------------------------------------
// pfde_back
// executes queued commands on the frame store and posts one result each
// ----------------------------------------------------------------------------
module pfde_back #(
    parameter int STORE_BYTES = 1024,
    parameter int ADDR_W      = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_empty,
    input  pfde_pkg::t_cmd_ctl    i_cmd_ctl,
    input  logic [ADDR_W-1:0]     i_cmd_first,
    input  logic [ADDR_W-1:0]     i_cmd_last,
    output logic                  o_cmd_pop,
    input  logic                  i_res_full,
    output logic                  o_res_push,
    output logic [7:0]            o_res_data,
    output logic                  o_res_ign,
    output pfde_pkg::t_back_stat  o_stat
);

    import pfde_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

    t_state            r_state;
    t_state            n_state;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] n_addr;
    logic [ADDR_W-1:0] r_last;
    logic [ADDR_W-1:0] n_last;
    t_cmd_ctl          r_ctl;
    t_cmd_ctl          n_ctl;
    logic [7:0]        r_fill;
    logic [7:0]        n_fill;

    logic              start;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    logic [7:0]        painted;

    pfde_ram #(
        .WIDTH  (8),
        .DEPTH  (STORE_BYTES),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // a command starts only with room for its result already reserved
    assign start = !i_cmd_empty && !i_res_full;
    assign o_stat.init_busy = (r_state == ST_INIT);

    always_comb begin
        case (r_ctl.color)
            COLOR_SET: painted = ram_rdata | r_ctl.mask;
            COLOR_CLR: painted = ram_rdata & ~r_ctl.mask;
            COLOR_XOR: painted = ram_rdata ^ r_ctl.mask;
            default:   painted = ram_rdata;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (r_addr == LAST_ADDR) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) begin
                    case (i_cmd_ctl.op)
                        OP_PIXEL, OP_LINE: n_state = ST_DRAW;
                        OP_CLEAR, OP_FILL: n_state = ST_SWEEP;
                        OP_READ:           n_state = ST_READ;
                        default:           n_state = ST_IDLE;
                    endcase
                end
            end
            ST_DRAW: begin
                if (r_addr == r_last) n_state = ST_IDLE;
            end
            ST_SWEEP: begin
                if (r_addr == LAST_ADDR) n_state = ST_IDLE;
            end
            ST_READ: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath updates
    always_comb begin
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res_data = BYTE_ZERO;
        o_res_ign  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_addr;
        ram_wdata  = BYTE_ZERO;
        ram_re     = 1'b0;
        ram_raddr  = r_addr;
        n_addr     = r_addr;
        n_last     = r_last;
        n_ctl      = r_ctl;
        n_fill     = r_fill;
        case (r_state)
            ST_INIT: begin
                ram_we = 1'b1;
                n_addr = r_addr + 1'b1;
            end
            ST_IDLE: begin
                if (start) begin
                    o_cmd_pop = 1'b1;
                    n_ctl     = i_cmd_ctl;
                    n_addr    = i_cmd_first;
                    n_last    = i_cmd_last;
                    n_fill    = (i_cmd_ctl.op == OP_FILL) ? BYTE_ONES : BYTE_ZERO;
                    ram_re    = 1'b1;
                    ram_raddr = i_cmd_first;
                    if (i_cmd_ctl.op == OP_NOP) begin
                        o_res_push = 1'b1;
                        o_res_ign  = i_cmd_ctl.ign;
                    end
                end
            end
            ST_DRAW: begin
                // write this byte while the next one is being read
                ram_we    = 1'b1;
                ram_wdata = painted;
                if (r_addr == r_last) begin
                    o_res_push = 1'b1;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_addr + 1'b1;
                    n_addr    = r_addr + 1'b1;
                end
            end
            ST_SWEEP: begin
                ram_we    = 1'b1;
                ram_wdata = r_fill;
                n_addr    = r_addr + 1'b1;
                if (r_addr == LAST_ADDR) begin
                    o_res_push = 1'b1;
                end
            end
            ST_READ: begin
                o_res_push = 1'b1;
                o_res_data = ram_rdata;
            end
            default: begin
                o_res_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last <= n_last;
        r_ctl  <= n_ctl;
        r_fill <= n_fill;
    end

endmodule

// File: hdl/page_framebuffer_draw_engine.sv
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine
// monochrome page-layout framebuffer with pixel, run, clear, fill and read
// ----------------------------------------------------------------------------
// flow: a beat reaches the command queue at once; the back end then answers
//   a no-op or off-screen beat from idle, does a read-modify-write of one byte
//   for a pixel, reads one byte back, and rewrites a run byte by byte and all
//   STORE_BYTES bytes for clear/fill, finishing each command before the next
// reset: a clearing pass writes zero to all STORE_BYTES bytes, one per cycle,
//   with full held high; results pending at reset are dropped
module page_framebuffer_draw_engine #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input side
    input  logic               push,
    output logic               full,
    input  logic [2:0]         i_action,
    input  logic signed [15:0] i_x_start,
    input  logic signed [15:0] i_x_end,
    input  logic signed [15:0] i_y_pos,
    input  logic [1:0]         i_color,
    input  logic [9:0]         i_byte_index,
    // result side
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         o_read_data,
    output logic               o_ignored
);

    import pfde_pkg::*;

    // store geometry: one byte per column for each page of eight rows
    localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_BYTES = PAGE_COUNT * SCREEN_WIDTH;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int CTL_W       = $bits(t_cmd_ctl);
    localparam int CMD_W       = CTL_W + 2 * ADDR_W;
    localparam int RES_W       = 9;
    localparam int CMD_DEPTH   = 2;
    localparam int RES_DEPTH   = 2;

    // front end outputs
    t_cmd_ctl          front_ctl;
    logic [ADDR_W-1:0] front_first;
    logic [ADDR_W-1:0] front_last;

    // command queue between front and back
    logic              cmd_push;
    logic              cmd_full;
    logic              cmd_pop;
    logic              cmd_empty;
    logic [CMD_W-1:0]  cmd_wdata;
    logic [CMD_W-1:0]  cmd_rdata;
    t_cmd_ctl          head_ctl;
    logic [ADDR_W-1:0] head_first;
    logic [ADDR_W-1:0] head_last;

    // result queue toward the consumer
    logic              res_push;
    logic              res_full;
    logic [7:0]        res_data;
    logic              res_ign;
    logic [RES_W-1:0]  res_rdata;

    t_back_stat        back_stat;

    // no beat is taken while the reset clearing pass runs
    assign full     = cmd_full || back_stat.init_busy;
    assign cmd_push = push && !full;

    pfde_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .STORE_BYTES   (STORE_BYTES),
        .ADDR_W        (ADDR_W)
    ) u_front (
        .i_action     (i_action),
        .i_x_start    (i_x_start),
        .i_x_end      (i_x_end),
        .i_y_pos      (i_y_pos),
        .i_color      (i_color),
        .i_byte_index (i_byte_index),
        .o_ctl        (front_ctl),
        .o_first      (front_first),
        .o_last       (front_last)
    );

    assign cmd_wdata = {front_ctl, front_first, front_last};
    assign head_ctl  = t_cmd_ctl'(cmd_rdata[CMD_W-1 -: CTL_W]);
    assign head_first = cmd_rdata[2*ADDR_W-1 -: ADDR_W];
    assign head_last  = cmd_rdata[ADDR_W-1:0];

    pfde_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_wdata (cmd_wdata),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_rdata (cmd_rdata),
        .o_empty (cmd_empty)
    );

    pfde_back #(
        .STORE_BYTES (STORE_BYTES),
        .ADDR_W      (ADDR_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd_ctl   (head_ctl),
        .i_cmd_first (head_first),
        .i_cmd_last  (head_last),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res_data  (res_data),
        .o_res_ign   (res_ign),
        .o_stat      (back_stat)
    );

    // result beat: read byte and off-screen flag
    pfde_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata ({res_data, res_ign}),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_rdata (res_rdata),
        .o_empty (empty)
    );

    assign o_read_data = res_rdata[RES_W-1:1];
    assign o_ignored   = res_rdata[0];

endmodule
